[sv/sra_pkg.sv]
// ----------------------------------------------------------------------------
// Space reservation admission package
// Shared widths, codes, payload types and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sra_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int BYTE_BITS   = 48;
    localparam int TAG_BITS    = 8;

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W  = BYTE_BITS + 2;
    localparam int CMD_W  = 2;
    localparam int KIND_W = 3;

    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STATS   = 2'd2;

    localparam logic [KIND_W-1:0] KIND_GRANTED  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_QUEUED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WOKEN    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DONE     = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [BYTE_BITS-1:0] amount;
        logic [TAG_BITS-1:0]  task_id;
        logic                 stat_ok;
        logic [BYTE_BITS-1:0] total_size;
        logic [BYTE_BITS-1:0] free_bytes;
    } sra_in_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [TAG_BITS-1:0]  tag;
        logic [CNT_W-1:0]     pending;
        logic [BYTE_BITS-1:0] available;
        logic                 last;
    } sra_out_t;

    typedef struct packed {
        logic [BYTE_BITS-1:0] amount;
        logic [TAG_BITS-1:0]  task_id;
    } sra_entry_t;

    typedef enum logic [1:0] {
        EMIT_DECIDE,
        EMIT_WOKEN,
        EMIT_DONE
    } sra_emit_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_PREP,
        ST_SUM,
        ST_DECIDE,
        ST_RESULT,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_HEAD_RD,
        ST_WOKEN,
        ST_DONE
    } sra_state_t;

    typedef struct packed {
        logic          load;
        logic          apply;
        logic          prep;
        logic          sum;
        logic          decide;
        logic          rd_walk;
        logic          step;
        logic          rd_head;
        logic          pop;
        logic          emit;
        sra_emit_sel_t emit_sel;
    } sra_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             fit;
        logic             walk_end;
        logic             walk_none;
        logic             out_free;
    } sra_sts_t;

endpackage

[sv/sra_ctrl.sv]
// ----------------------------------------------------------------------------
// Space reservation admission controller
// Sequences apply, limit setup, admission decision, queue walk and result emit.
// ----------------------------------------------------------------------------
module sra_ctrl
    import sra_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  sra_sts_t sts,
    output sra_ctl_t ctl
);

    sra_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ctl        = '0;
        ctl.emit_sel = EMIT_DONE;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                ctl.load = s_valid;
                if (s_valid) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                ctl.apply = 1'b1;
                if (sts.cmd == CMD_REQUEST || sts.cmd == CMD_RELEASE) begin
                    state_next = ST_PREP;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_PREP: begin
                ctl.prep   = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                ctl.sum = 1'b1;
                if (sts.cmd == CMD_REQUEST) begin
                    state_next = ST_DECIDE;
                end else begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_DECIDE: begin
                ctl.decide = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                ctl.emit_sel = EMIT_DECIDE;
                if (sts.out_free) begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WALK_RD: begin
                if (sts.walk_end) begin
                    state_next = ST_HEAD_RD;
                end else begin
                    ctl.rd_walk = 1'b1;
                    state_next  = ST_WALK_CHK;
                end
            end
            ST_WALK_CHK: begin
                if (sts.fit) begin
                    ctl.step   = 1'b1;
                    state_next = ST_WALK_RD;
                end else begin
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD: begin
                if (sts.walk_none) begin
                    state_next = ST_DONE;
                end else begin
                    ctl.rd_head = 1'b1;
                    state_next  = ST_WOKEN;
                end
            end
            ST_WOKEN: begin
                ctl.emit_sel = EMIT_WOKEN;
                if (sts.out_free) begin
                    ctl.emit   = 1'b1;
                    ctl.pop    = 1'b1;
                    state_next = ST_HEAD_RD;
                end
            end
            ST_DONE: begin
                ctl.emit_sel = EMIT_DONE;
                if (sts.out_free) begin
                    ctl.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/sra_dp.sv]
// ----------------------------------------------------------------------------
// Space reservation admission datapath
// Statistics, reservation, admission adder, wait queue memory, output register.
// ----------------------------------------------------------------------------
module sra_dp
    import sra_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sra_in_t              s_item,
    input  logic                 cfg_we,
    input  logic [BYTE_BITS-1:0] cfg_data,
    input  logic                 m_ready,
    output logic                 m_valid,
    output sra_out_t             m_item,
    input  sra_ctl_t             ctl,
    output sra_sts_t             sts
);

    localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(QUEUE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

    function automatic logic [IDX_W-1:0] inc_idx(input logic [IDX_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    logic [BYTE_BITS-1:0] min_free_reg, min_free_next;
    logic [BYTE_BITS-1:0] size_reg, size_next;
    logic [BYTE_BITS-1:0] free_reg, free_next;
    logic [BYTE_BITS-1:0] reserved_reg, reserved_next;
    logic [BYTE_BITS-1:0] inuse_reg, inuse_next;
    logic [BYTE_BITS-1:0] limit_reg, limit_next;
    logic                 lim_ok_reg, lim_ok_next;
    logic [SUM_W-1:0]     need_reg, need_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     walk_n_reg, walk_n_next;
    sra_in_t              item_reg, item_next;
    logic [KIND_W-1:0]    dec_kind_reg, dec_kind_next;
    logic                 m_valid_reg, m_valid_next;
    sra_out_t             m_item_reg, m_item_next;

    sra_entry_t           mem [QUEUE_DEPTH];
    sra_entry_t           rd_reg;

    logic [BYTE_BITS-1:0] cand_amt;
    logic [BYTE_BITS-1:0] avail;
    logic [SUM_W-1:0]     cand_sum;
    logic [IDX_W:0]       tail_sum;
    logic [IDX_W:0]       tail_wrap;
    logic [IDX_W-1:0]     tail;
    logic [IDX_W-1:0]     rd_addr;
    logic                 mem_we;
    logic                 mem_re;
    logic                 fit;
    logic                 out_free;

    assign cand_amt  = ctl.decide ? item_reg.amount : rd_reg.amount;
    assign cand_sum  = need_reg + SUM_W'(cand_amt);
    assign fit       = lim_ok_reg && (cand_sum <= SUM_W'(limit_reg));
    assign avail     = (free_reg > reserved_reg) ? free_reg - reserved_reg : '0;
    assign out_free  = !m_valid_reg || m_ready;
    assign tail_sum  = {1'b0, head_reg} + (IDX_W + 1)'(count_reg);
    assign tail_wrap = (tail_sum >= DEPTH_X) ? tail_sum - DEPTH_X : tail_sum;
    assign tail      = tail_wrap[IDX_W-1:0];
    assign rd_addr   = ctl.rd_head ? head_reg : ptr_reg;
    assign mem_re    = ctl.rd_walk || ctl.rd_head;

    always_comb begin
        min_free_next = min_free_reg;
        size_next     = size_reg;
        free_next     = free_reg;
        reserved_next = reserved_reg;
        inuse_next    = inuse_reg;
        limit_next    = limit_reg;
        lim_ok_next   = lim_ok_reg;
        need_next     = need_reg;
        head_next     = head_reg;
        ptr_next      = ptr_reg;
        count_next    = count_reg;
        walk_n_next   = walk_n_reg;
        item_next     = item_reg;
        dec_kind_next = dec_kind_reg;
        m_valid_next  = m_valid_reg;
        m_item_next   = m_item_reg;
        mem_we        = 1'b0;

        if (cfg_we) begin
            min_free_next = cfg_data;
        end
        if (ctl.load) begin
            item_next = s_item;
        end
        if (ctl.apply) begin
            if (item_reg.cmd == CMD_RELEASE) begin
                reserved_next = (item_reg.amount >= reserved_reg) ? '0 :
                                reserved_reg - item_reg.amount;
            end
            if ((item_reg.cmd == CMD_RELEASE || item_reg.cmd == CMD_STATS) &&
                item_reg.stat_ok) begin
                size_next = item_reg.total_size;
                free_next = item_reg.free_bytes;
            end
        end
        if (ctl.prep) begin
            inuse_next  = (size_reg >= free_reg) ? size_reg - free_reg : '0;
            limit_next  = size_reg - min_free_reg;
            lim_ok_next = (min_free_reg <= size_reg);
            walk_n_next = '0;
            ptr_next    = head_reg;
        end
        if (ctl.sum) begin
            need_next = SUM_W'(inuse_reg) + SUM_W'(reserved_reg);
        end
        if (ctl.decide) begin
            if (fit) begin
                reserved_next = reserved_reg + item_reg.amount;
                dec_kind_next = KIND_GRANTED;
            end else if (count_reg < DEPTH_C) begin
                mem_we        = 1'b1;
                count_next    = count_reg + 1'b1;
                dec_kind_next = KIND_QUEUED;
            end else begin
                dec_kind_next = KIND_REJECTED;
            end
        end
        if (ctl.step) begin
            need_next   = cand_sum;
            walk_n_next = walk_n_reg + 1'b1;
            ptr_next    = inc_idx(ptr_reg);
        end
        if (ctl.pop) begin
            head_next   = inc_idx(head_reg);
            count_next  = count_reg - 1'b1;
            walk_n_next = walk_n_reg - 1'b1;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (ctl.emit) begin
            m_valid_next          = 1'b1;
            m_item_next.pending   = count_reg - walk_n_reg;
            m_item_next.available = avail;
            case (ctl.emit_sel)
                EMIT_DECIDE: begin
                    m_item_next.kind = dec_kind_reg;
                    m_item_next.tag  = item_reg.task_id;
                    m_item_next.last = 1'b1;
                end
                EMIT_WOKEN: begin
                    m_item_next.kind = KIND_WOKEN;
                    m_item_next.tag  = rd_reg.task_id;
                    m_item_next.last = 1'b0;
                end
                default: begin
                    m_item_next.kind = KIND_DONE;
                    m_item_next.tag  = '0;
                    m_item_next.last = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_free_reg <= '0;
            size_reg     <= '0;
            free_reg     <= '0;
            reserved_reg <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            walk_n_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            min_free_reg <= min_free_next;
            size_reg     <= size_next;
            free_reg     <= free_next;
            reserved_reg <= reserved_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            walk_n_reg   <= walk_n_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        inuse_reg    <= inuse_next;
        limit_reg    <= limit_next;
        lim_ok_reg   <= lim_ok_next;
        need_reg     <= need_next;
        ptr_reg      <= ptr_next;
        item_reg     <= item_next;
        dec_kind_reg <= dec_kind_next;
        m_item_reg   <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[tail] <= '{amount: item_reg.amount, task_id: item_reg.task_id};
        end
        if (mem_re) begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_item        = m_item_reg;
    assign sts.cmd       = item_reg.cmd;
    assign sts.fit       = fit;
    assign sts.walk_end  = (walk_n_reg == count_reg);
    assign sts.walk_none = (walk_n_reg == '0);
    assign sts.out_free  = out_free;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("wait count beyond queue depth");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_n_reg <= count_reg)
        else $error("walk count beyond wait count");

    a_head_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, head_reg} < DEPTH_X)
        else $error("queue head out of range");

    a_final_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.emit && ctl.emit_sel != EMIT_WOKEN) |-> (walk_n_reg == '0))
        else $error("final result with woken requests still unsent");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pop |-> (count_reg != '0 && walk_n_reg != '0))
        else $error("pop from empty queue");
`endif

endmodule

[sv/space_reservation_admission_top.sv]
// ----------------------------------------------------------------------------
// Space reservation admission top level
// Admission control for storage space with a wait queue of requests.
// ----------------------------------------------------------------------------
// Request: apply, limit setup, sum, decide and result states after accept.
// Statistics item: apply and done states. Next item is taken only in idle.
// Release: apply, limit setup, sum, then a read and check per entry checked,
// a head read and woken state per woken request, a final head read and done;
// walk and wake share the single read port of the wait queue memory.
// Each result waits while the output register holds an unaccepted one.
// Reset clears statistics, reservation and queue pointers; no clearing pass.
// ----------------------------------------------------------------------------
module space_reservation_admission_top
    import sra_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sra_in_t              s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sra_out_t             m_item,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [BYTE_BITS-1:0] cfg_data
);

    sra_ctl_t ctl;
    sra_sts_t sts;

    assign cfg_ready = 1'b1;

    sra_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    sra_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_item   (s_item),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_ready  (m_ready),
        .m_valid  (m_valid),
        .m_item   (m_item),
        .ctl      (ctl),
        .sts      (sts)
    );

endmodule

[tb/sv/tb_space_reservation_admission_top.sv]
// ----------------------------------------------------------------------------
// Space reservation admission testbench
// Drives requests, releases and statistics items through the valid/ready
// channels, keeps its own copy of the space accounting and the wait queue,
// and compares every result field by field in arrival order. Directed items
// cover the corner cases; random traffic runs under several idle patterns,
// minimum free settings and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_space_reservation_admission_top;
    import sra_pkg::*;

    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int QUIET_LIMIT     = 4000;
    localparam logic [BYTE_BITS-1:0] BYTES_MAX = '1;
    localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    sra_in_t              s_item    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    sra_out_t             m_item;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [BYTE_BITS-1:0] cfg_data  = '0;

    logic [BYTE_BITS-1:0] floor_bytes = '0;
    logic [BYTE_BITS-1:0] disk_size   = '0;
    logic [BYTE_BITS-1:0] disk_free   = '0;
    logic [BYTE_BITS-1:0] held_bytes  = '0;
    sra_entry_t           waiters[$];
    sra_out_t             outcomes_due[$];
    sra_out_t             due_head;

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_req_seq  = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int mismatch_count = 0;

    space_reservation_admission_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic bit room_for(input logic [63:0] extra_a, input logic [63:0] extra_b);
        logic [63:0] sum;
        if (floor_bytes > disk_size) return 1'b0;
        sum = (disk_size >= disk_free) ? 64'(disk_size - disk_free) : 64'd0;
        sum = sum + 64'(held_bytes) + extra_a + extra_b;
        return sum <= 64'(disk_size - floor_bytes);
    endfunction

    function automatic void push_outcome(input logic [KIND_W-1:0] kind,
                                         input logic [TAG_BITS-1:0] tag,
                                         input logic last);
        sra_out_t r;
        r.kind      = kind;
        r.tag       = tag;
        r.pending   = CNT_W'(waiters.size());
        r.available = (disk_free > held_bytes) ? disk_free - held_bytes : '0;
        r.last      = last;
        outcomes_due.insert(outcomes_due.size(), r);
    endfunction

    function automatic void admit_item(input sra_in_t it);
        logic [63:0]         woken_sum;
        logic [TAG_BITS-1:0] woken_tags[$];
        logic [KIND_W-1:0]   verdict;
        sra_entry_t          entry;
        woken_sum = '0;
        case (it.cmd)
            CMD_REQUEST: begin
                if (room_for(64'(it.amount), 64'd0)) begin
                    held_bytes = held_bytes + it.amount;
                    verdict    = KIND_GRANTED;
                end else if (waiters.size() < QUEUE_DEPTH) begin
                    entry.amount  = it.amount;
                    entry.task_id = it.task_id;
                    waiters.insert(waiters.size(), entry);
                    verdict = KIND_QUEUED;
                end else begin
                    verdict = KIND_REJECTED;
                end
                push_outcome(verdict, it.task_id, 1'b1);
                return;
            end
            CMD_RELEASE: begin
                held_bytes = (it.amount >= held_bytes) ? '0 : held_bytes - it.amount;
                if (it.stat_ok) begin
                    disk_size = it.total_size;
                    disk_free = it.free_bytes;
                end
                while (waiters.size() > 0 && room_for(64'(waiters[0].amount), woken_sum)) begin
                    woken_sum = woken_sum + 64'(waiters[0].amount);
                    woken_tags.insert(woken_tags.size(), waiters[0].task_id);
                    waiters.delete(0);
                end
            end
            CMD_STATS: begin
                if (it.stat_ok) begin
                    disk_size = it.total_size;
                    disk_free = it.free_bytes;
                end
            end
            default: ;
        endcase
        foreach (woken_tags[i]) push_outcome(KIND_WOKEN, woken_tags[i], 1'b0);
        push_outcome(KIND_DONE, '0, 1'b1);
    endfunction

    function automatic logic [BYTE_BITS-1:0] pick_bytes(input logic [BYTE_BITS-1:0] hi);
        logic [63:0] r;
        r = {$urandom, $urandom};
        if (hi == BYTES_MAX) return r[BYTE_BITS-1:0];
        return BYTE_BITS'(r % (64'(hi) + 64'd1));
    endfunction

    function automatic logic [BYTE_BITS-1:0] pick_free_bytes(input logic [BYTE_BITS-1:0] cap);
        if ($urandom_range(7) == 0) return pick_bytes(BYTES_MAX);
        return pick_bytes(cap);
    endfunction

    function automatic logic [BYTE_BITS-1:0] pick_capacity(input int lo_bits, input int hi_bits);
        int k;
        k = $urandom_range(hi_bits, lo_bits);
        return pick_bytes((48'd1 << k) - 48'd1) | (48'd1 << (k - 1));
    endfunction

    function automatic sra_in_t make_item(input logic [CMD_W-1:0]     cmd,
                                          input logic [BYTE_BITS-1:0] amount,
                                          input logic [TAG_BITS-1:0]  task_id,
                                          input logic                 stat_ok,
                                          input logic [BYTE_BITS-1:0] total_size,
                                          input logic [BYTE_BITS-1:0] free_bytes);
        sra_in_t it;
        it.cmd        = cmd;
        it.amount     = amount;
        it.task_id    = task_id;
        it.stat_ok    = stat_ok;
        it.total_size = total_size;
        it.free_bytes = free_bytes;
        return it;
    endfunction

    task automatic send_item(input sra_in_t it);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        admit_item(it);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_min_free(input logic [BYTE_BITS-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        floor_bytes = value;
    endtask

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (outcomes_due.size() == 0) begin
                $display("%0t: result with nothing due, expected none actual %p",
                         $time, m_item);
                mismatch_count++;
            end else begin
                due_head = outcomes_due[0];
                outcomes_due.delete(0);
                compare_field("kind", 64'(due_head.kind), 64'(m_item.kind));
                compare_field("tag", 64'(due_head.tag), 64'(m_item.tag));
                compare_field("pending", 64'(due_head.pending), 64'(m_item.pending));
                compare_field("available", 64'(due_head.available),
                              64'(m_item.available));
                compare_field("last", 64'(due_head.last), 64'(m_item.last));
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_req_seq) begin
            hold_seen <= hold_req_seq;
            hold_left <= HOLD_OFF_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_statistics_and_commands();
        write_min_free('0);
        send_item(make_item(CMD_SPARE, BYTES_MAX, 8'hff, 1'b1, BYTES_MAX, BYTES_MAX));
        send_item(make_item(CMD_REQUEST, '0, 8'h00, 1'b0, '0, '0));
        send_item(make_item(CMD_REQUEST, 48'd1, 8'h5a, 1'b0, '0, '0));
        send_item(make_item(CMD_STATS, '0, 8'h00, 1'b0, BYTES_MAX, BYTES_MAX));
        send_item(make_item(CMD_STATS, '0, 8'h00, 1'b1, 48'd1000, 48'd600));
        send_item(make_item(CMD_REQUEST, 48'd600, 8'ha5, 1'b1, 48'd5, 48'd5));
        send_item(make_item(CMD_REQUEST, 48'd1, 8'h11, 1'b0, '0, '0));
        send_item(make_item(CMD_RELEASE, 48'd300, 8'h00, 1'b0, '0, '0));
        send_item(make_item(CMD_RELEASE, BYTES_MAX, 8'h00, 1'b0, '0, '0));
        send_item(make_item(CMD_STATS, '0, 8'h00, 1'b1, 48'd100, 48'd500));
        send_item(make_item(CMD_REQUEST, 48'd100, 8'h33, 1'b0, '0, '0));
        send_item(make_item(CMD_REQUEST, 48'd1, 8'h34, 1'b0, '0, '0));
        send_item(make_item(CMD_RELEASE, 48'd50, 8'h00, 1'b1, BYTES_MAX, '0));
        send_item(make_item(CMD_REQUEST, BYTES_MAX, 8'hff, 1'b0, '0, '0));
        send_item(make_item(CMD_RELEASE, '0, 8'h00, 1'b1, BYTES_MAX, BYTES_MAX));
    endtask

    task automatic test_min_free_limits();
        write_min_free(48'd200);
        send_item(make_item(CMD_STATS, '0, 8'h00, 1'b1, 48'd150, 48'd150));
        send_item(make_item(CMD_REQUEST, '0, 8'h77, 1'b0, '0, '0));
        write_min_free(BYTES_MAX);
        send_item(make_item(CMD_STATS, '0, 8'h00, 1'b1, BYTES_MAX, BYTES_MAX));
        send_item(make_item(CMD_RELEASE, 48'd50, 8'h00, 1'b0, '0, '0));
        send_item(make_item(CMD_REQUEST, '0, 8'h78, 1'b0, '0, '0));
        write_min_free('0);
        send_item(make_item(CMD_RELEASE, '0, 8'h00, 1'b1, BYTES_MAX, BYTES_MAX));
    endtask

    // fill the wait queue past its depth, then release with ample space
    task automatic run_burst_episode(output int sent);
        logic [BYTE_BITS-1:0] cap;
        cap = pick_capacity(12, 40);
        send_item(make_item(CMD_STATS, pick_bytes(BYTES_MAX), TAG_BITS'($urandom), 1'b1,
                            cap, cap >> 3));
        sent = 1;
        repeat ($urandom_range(19, 17)) begin
            send_item(make_item(CMD_REQUEST, pick_bytes(cap >> 2) + (cap >> 2),
                                TAG_BITS'($urandom), 1'($urandom),
                                pick_bytes(BYTES_MAX), pick_bytes(BYTES_MAX)));
            sent++;
        end
        send_item(make_item(CMD_RELEASE, pick_bytes(cap >> 3), TAG_BITS'($urandom), 1'b1,
                            BYTES_MAX, BYTES_MAX));
        sent++;
    endtask

    task automatic run_steady_episode(output int sent);
        logic [BYTE_BITS-1:0] cap;
        sra_in_t              it;
        int                   pick;
        cap = ($urandom_range(15) == 0) ? BYTES_MAX : pick_capacity(11, 47);
        send_item(make_item(CMD_STATS, pick_bytes(BYTES_MAX), TAG_BITS'($urandom), 1'b1,
                            cap, pick_free_bytes(cap)));
        sent = 1;
        repeat ($urandom_range(14, 6)) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                it = make_item(CMD_REQUEST, pick_bytes(cap >> $urandom_range(5, 1)),
                               TAG_BITS'($urandom), 1'($urandom),
                               pick_bytes(BYTES_MAX), pick_bytes(BYTES_MAX));
            end else if (pick < 78) begin
                it = make_item(CMD_RELEASE, pick_bytes(cap >> 2), TAG_BITS'($urandom),
                               ($urandom_range(2) == 0), cap, pick_free_bytes(cap));
            end else if (pick < 90) begin
                it = make_item(CMD_STATS, pick_bytes(BYTES_MAX), TAG_BITS'($urandom),
                               1'($urandom), cap, pick_free_bytes(cap));
            end else begin
                it = make_item(CMD_W'($urandom), pick_bytes(BYTES_MAX), TAG_BITS'($urandom),
                               1'($urandom), pick_bytes(BYTES_MAX), pick_bytes(BYTES_MAX));
            end
            send_item(it);
            if (it.cmd inside {CMD_REQUEST, CMD_RELEASE, CMD_STATS}) sent++;
        end
    endtask

    task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                       input logic [BYTE_BITS-1:0] floor_value,
                                       input int goal);
        int sent;
        int n;
        write_min_free(floor_value);
        snd_idle_pct  = snd_pct;
        rcv_stall_pct = rcv_pct;
        run_burst_episode(sent);
        while (sent < goal) begin
            if ($urandom_range(3) == 0) begin
                run_burst_episode(n);
            end else begin
                run_steady_episode(n);
            end
            sent += n;
        end
    endtask

    task automatic test_output_hold_off();
        int n;
        wait_idle();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_req_seq <= hold_req_seq + 1;
        run_steady_episode(n);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_statistics_and_commands();
        test_min_free_limits();
        test_random_traffic(0, 0, '0, 62);
        test_random_traffic(87, 0, pick_bytes(48'd1023), 62);
        test_random_traffic(0, 87, pick_bytes(48'd65535), 62);
        test_output_hold_off();
        test_random_traffic(32, 32, pick_bytes(48'd255), 62);
        wait_idle();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[sim.f]
sv/sra_pkg.sv
sv/sra_ctrl.sv
sv/sra_dp.sv
sv/space_reservation_admission_top.sv
tb/sv/tb_space_reservation_admission_top.sv
